### hw/rtl/ceq_pkg.sv
// Package for the click event queue: sizes, opcodes and beat/entry structs.
// No dependencies; every other file of the block depends on it.
package ceq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int FILL_W      = 7;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_TAKE  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic               match_any;
      logic [7:0]         window_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] button_code;
      logic               is_motion;
      logic               is_release;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               dropped_oldest;
      logic [7:0]         out_window;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_button;
      logic [FILL_W-1:0]  fill_count;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         window;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] button;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic    valid;
      rsp_type result;
   } done_type;

endpackage

### hw/rtl/ceq_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on ceq_pkg for the payload structs.
interface ceq_req_if;
   logic              valid;
   logic              ready;
   ceq_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ceq_rsp_if;
   logic              valid;
   logic              ready;
   ceq_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/ceq_store.sv
// Event store: one write port and one registered read port.
// Depends on ceq_pkg for the entry and access structs.
module ceq_store (
   input  logic                 clock,
   input  ceq_pkg::mem_req_type mem,
   output ceq_pkg::entry_type   rd_data
);
   import ceq_pkg::*;

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem.wr_en) begin
         mem_ff[mem.wr_addr] <= mem.wr_data;
      end
      if (mem.rd_en) begin
         rd_data_ff <= mem_ff[mem.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ceq_ctrl.sv
// Sequencer: decodes a request, walks the ring buffer one entry a cycle
// through the store port and the window compare. Depends on ceq_pkg.
module ceq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  ceq_pkg::req_type     req_payload,
   output logic                 req_ready,
   input  logic                 rsp_free,
   output ceq_pkg::done_type    done,
   output ceq_pkg::mem_req_type mem,
   input  ceq_pkg::entry_type   rd_data
);
   import ceq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_SWEEP = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           res_ff, res_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  keep_ff, keep_in;
   logic              dv_ff, dv_in;
   logic              found_ff, found_in;

   logic                     full;
   logic                     entry_match;
   logic                     remove;
   logic [ADDR_W-1:0]        head_next;
   logic [CNT_W+FILL_W-1:0]  count_wide;

   function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                              input logic [CNT_W-1:0]  idx);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, idx};
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   assign full        = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_next   = (head_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + ADDR_W'(1);
   assign entry_match = req_ff.match_any || (rd_data.window == req_ff.window_id);
   assign remove      = (req_ff.opcode == OP_TAKE) ? (!found_ff && entry_match) : entry_match;
   assign count_wide  = {{FILL_W{1'b0}}, count_ff};
   assign req_ready   = (state_ff == S_IDLE);

   always_comb begin
      done.valid             = (state_ff == S_DONE);
      done.result            = res_ff;
      done.result.fill_count = count_wide[FILL_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      res_in   = res_ff;
      head_in  = head_ff;
      count_in = count_ff;
      rd_in    = rd_ff;
      keep_in  = keep_ff;
      dv_in    = dv_ff;
      found_in = found_ff;
      mem      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in   = '0;
            rd_in    = '0;
            keep_in  = '0;
            dv_in    = 1'b0;
            found_in = 1'b0;
            state_in = S_DONE;
            unique case (req_ff.opcode)
               OP_PUSH: begin
                  if (!req_ff.is_motion && !req_ff.is_release) begin
                     res_in.hit            = 1'b1;
                     mem.wr_en             = 1'b1;
                     mem.wr_data.window    = req_ff.window_id;
                     mem.wr_data.x         = req_ff.pos_x;
                     mem.wr_data.y         = req_ff.pos_y;
                     mem.wr_data.button    = req_ff.button_code;
                     if (full) begin
                        mem.wr_addr           = head_ff;
                        head_in               = head_next;
                        res_in.dropped_oldest = 1'b1;
                     end else begin
                        mem.wr_addr = phys(head_ff, count_ff);
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
               end
               OP_TAKE: begin
                  state_in = S_SWEEP;
               end
               OP_CLEAR: begin
                  if (req_ff.match_any) begin
                     count_in = '0;
                  end else begin
                     state_in = S_SWEEP;
                  end
               end
               OP_NOP: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SWEEP: begin
            dv_in = 1'b0;
            if (rd_ff < count_ff) begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = phys(head_ff, rd_ff);
               rd_in       = rd_ff + CNT_W'(1);
               dv_in       = 1'b1;
            end
            if (dv_ff) begin
               if (remove) begin
                  if (req_ff.opcode == OP_TAKE) begin
                     found_in          = 1'b1;
                     res_in.out_window = rd_data.window;
                     res_in.out_x      = rd_data.x;
                     res_in.out_y      = rd_data.y;
                     res_in.out_button = rd_data.button;
                  end
               end else begin
                  mem.wr_en   = 1'b1;
                  mem.wr_addr = phys(head_ff, keep_ff);
                  mem.wr_data = rd_data;
                  keep_in     = keep_ff + CNT_W'(1);
               end
            end else if (rd_ff == count_ff) begin
               res_in.hit = found_ff;
               count_in   = keep_ff;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         dv_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         dv_ff    <= dv_in;
         found_ff <= found_in;
      end
      req_ff  <= req_in;
      res_ff  <= res_in;
      rd_ff   <= rd_in;
      keep_ff <= keep_in;
   end

endmodule

### hw/rtl/click_event_queue_core.sv
// Click event queue top: sequencer, event store and response register.
// Push, clear-all and no-op pass through the execute and done states; take
// and per-window clear also walk the queue through the store's read and
// write ports. One request is in work: the next is taken only once the
// last result is in the response register. Reset clears head, count and
// handshake state; store contents are left as is, never read before written.
module click_event_queue_core (
   input logic        clock,
   input logic        reset,
   ceq_req_if.sink    req_chan,
   ceq_rsp_if.source  rsp_chan
);
   import ceq_pkg::*;

   done_type    done;
   mem_req_type mem;
   entry_type   rd_data;
   logic        rsp_free;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   ceq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_payload (req_chan.payload),
      .req_ready   (req_chan.ready),
      .rsp_free    (rsp_free),
      .done        (done),
      .mem         (mem),
      .rd_data     (rd_data)
   );

   ceq_store u_store (
      .clock   (clock),
      .mem     (mem),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done.valid && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

### hw/rtl/ceq_checker.sv
// Port-level checks for click_event_queue_core, attached by bind.
// Depends on ceq_pkg for the response struct and queue depth.
module ceq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ceq_pkg::rsp_type rsp_payload
);
   import ceq_pkg::*;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request beat taken while previous one in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response beat changed");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.dropped_oldest |->
         rsp_payload.hit && (rsp_payload.fill_count == FILL_W'(QUEUE_DEPTH)))
      else $error("drop reported without full queue");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit |->
         rsp_payload.out_window == '0 && rsp_payload.out_x == '0 &&
         rsp_payload.out_y == '0 && rsp_payload.out_button == '0 &&
         !rsp_payload.dropped_oldest)
      else $error("miss response carries data");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind click_event_queue_core ceq_checker u_ceq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
